// ===== sv/enh_pkg.sv =====
package enh_pkg;

	// region codes of the result item
	typedef enum logic [2:0] {
		RGN_MAIN         = 3'd0,
		RGN_TOP          = 3'd1,
		RGN_RIGHT        = 3'd2,
		RGN_CENTER       = 3'd3,
		RGN_CORNER_TOP   = 3'd4,
		RGN_CORNER_RIGHT = 3'd5
	} region_t;

	// status codes of the result item
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_REGION = 2'd1,
		ST_NONPOS    = 2'd2
	} status_t;

	// configuration register indexes
	localparam logic [2:0] CFG_MU     = 3'd0;
	localparam logic [2:0] CFG_LAMBDA = 3'd1;
	localparam logic [2:0] CFG_EXTRAP = 3'd2;
	localparam logic [2:0] CFG_CORNER = 3'd3;
	localparam logic [2:0] CFG_KCOEF  = 3'd4;

	// register reset values, Q16.16
	localparam logic [30:0] MU_RST     = 31'd65536;
	localparam logic [30:0] LAMBDA_RST = 31'd65536;
	localparam logic [30:0] EXTRAP_RST = 31'd19661;
	localparam logic [30:0] CORNER_RST = 31'd6554;
	localparam logic [30:0] KCOEF_RST  = 31'd0;

	// ln(2) in Q0.32
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	// datapath widths
	localparam int SQ_STEPS = 16;   // log2 fraction bits, one squaring each
	localparam int DIV_W    = 54;   // quotient bits of n / s
	localparam int PEN_W    = 52;   // penalty term
	localparam int MS_W     = 48;   // mu * s term
	localparam int SUM_W    = 49;   // clamped sum

	// clamp bounds of the wide sum, +-2^47
	localparam logic signed [56:0] SUM_MAX = 57'sd140737488355328;
	localparam logic signed [56:0] SUM_MIN = -57'sd140737488355328;

	// per-item context carried down the pipeline
	typedef struct packed {
		logic signed [31:0]      x;
		logic signed [31:0]      y;
		logic signed [31:0]      scale;
		region_t                 rgn;
		status_t                 st;
		logic signed [PEN_W-1:0] pen1;
		logic signed [PEN_W-1:0] pen2;
		logic signed [MS_W-1:0]  ms1;
		logic signed [MS_W-1:0]  ms2;
	} ctx_t;

endpackage

// ===== sv/extrapolated_neo_hookean_stress.sv =====
// Channel   Handshake                Payload
// in        in_valid / in_stall      stretch_1, stretch_2, stress_scale
// out       out_valid / out_stall    stress_1, stress_2, region, status
// cfg       cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One item per cycle sustained while out is not stalled; the pipeline depth is
// set by the 16 squaring stages of the log and the 54 quotient stages of the
// two restoring dividers.
// arst_n clears all stage valid bits and loads the register reset values.
// A stall on out only holds stages that are full; empty stages keep filling.
module extrapolated_neo_hookean_stress (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] stretch_1,
	input  logic signed [31:0] stretch_2,
	input  logic signed [31:0] stress_scale,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] stress_1,
	output logic signed [31:0] stress_2,
	output logic [2:0]         region,
	output logic [1:0]         status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int SQW     = enh_pkg::SQ_STEPS;
	localparam int DW      = enh_pkg::DIV_W;
	localparam int PW      = enh_pkg::PEN_W;
	localparam int MW      = enh_pkg::MS_W;
	localparam int ST_S1   = 0;
	localparam int ST_S2   = 1;
	localparam int ST_S3   = 2;
	localparam int ST_SQ0  = 3;
	localparam int ST_LN   = ST_SQ0 + SQW;
	localparam int ST_N    = ST_LN + 1;
	localparam int ST_ABS  = ST_N + 1;
	localparam int ST_DIV0 = ST_ABS + 1;
	localparam int ST_SUM  = ST_DIV0 + DW;
	localparam int ST_MUL  = ST_SUM + 1;
	localparam int ST_OUT  = ST_MUL + 1;
	localparam int NST     = ST_OUT + 1;

	// configuration registers
	logic [30:0] mu_q, lambda_q, a_q, r_q, k_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_q     <= enh_pkg::MU_RST;
			lambda_q <= enh_pkg::LAMBDA_RST;
			a_q      <= enh_pkg::EXTRAP_RST;
			r_q      <= enh_pkg::CORNER_RST;
			k_q      <= enh_pkg::KCOEF_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				enh_pkg::CFG_MU:     mu_q     <= cfg_data[30:0];
				enh_pkg::CFG_LAMBDA: lambda_q <= cfg_data[30:0];
				enh_pkg::CFG_EXTRAP: a_q      <= cfg_data[30:0];
				enh_pkg::CFG_CORNER: r_q      <= cfg_data[30:0];
				enh_pkg::CFG_KCOEF:  k_q      <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// stage valid bits and advance chain
	logic [NST-1:0] vld_s;
	logic [NST-1:0] adv;

	always_comb begin
		adv[NST-1] = !vld_s[NST-1] || !out_stall;
		for (int i = NST - 2; i >= 0; i--) begin
			adv[i] = !vld_s[i] || adv[i+1];
		end
	end

	assign in_stall  = !adv[0];
	assign out_valid = vld_s[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int i = 1; i < NST; i++) begin
				if (adv[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	enh_pkg::ctx_t ctx_s [0:NST-2];

	// ---------------- stage 1: region, penalty operands, x*y ----------------
	logic signed [34:0]   xs, ys, a35, r35, ar35, cut35, xy35;
	logic [31:0]          k1, k2;
	enh_pkg::region_t     rgn_c;
	enh_pkg::status_t     st_c;
	logic signed [34:0]   d1_c, d2_c;
	logic [31:0]          c1_c, c2_c;
	logic signed [63:0]   j_c;

	assign xs    = 35'(stretch_1);
	assign ys    = 35'(stretch_2);
	assign a35   = $signed({4'b0, a_q});
	assign r35   = $signed({4'b0, r_q});
	assign ar35  = a35 + r35;
	assign cut35 = r35 + a35 + a35;
	assign xy35  = xs + ys;
	assign k1    = {1'b0, k_q};
	assign k2    = {k_q, 1'b0};
	assign j_c   = stretch_1 * stretch_2;

	always_comb begin
		rgn_c = enh_pkg::RGN_MAIN;
		st_c  = enh_pkg::ST_OK;
		d1_c  = '0;
		d2_c  = '0;
		c1_c  = '0;
		c2_c  = '0;
		if (xs >= a35 && ys >= a35 && xy35 >= cut35) begin
			rgn_c = enh_pkg::RGN_MAIN;
		end else if (ys >= ar35 && xs < a35) begin
			rgn_c = enh_pkg::RGN_TOP;
			d1_c  = xs - a35;
			c1_c  = k2;
		end else if (xs >= ar35 && ys < a35) begin
			rgn_c = enh_pkg::RGN_RIGHT;
			d2_c  = ys - a35;
			c2_c  = k2;
		end else if (ys <= r35 + xs && xs <= r35 + ys && xy35 < cut35) begin
			rgn_c = enh_pkg::RGN_CENTER;
			d1_c  = xy35 - cut35;
			d2_c  = xy35 - cut35;
			c1_c  = k1;
			c2_c  = k1;
		end else if (ys > xs + r35 && ys < ar35) begin
			rgn_c = enh_pkg::RGN_CORNER_TOP;
			d1_c  = xs - a35;
			c1_c  = k2;
			d2_c  = ys - ar35;
			c2_c  = k2;
		end else if (xs > ys + r35 && xs < ar35) begin
			rgn_c = enh_pkg::RGN_CORNER_RIGHT;
			d1_c  = xs - ar35;
			c1_c  = k2;
			d2_c  = ys - a35;
			c2_c  = k2;
		end else begin
			st_c = enh_pkg::ST_NO_REGION;
		end
	end

	logic signed [34:0] d1_s1, d2_s1;
	logic [31:0]        c1_s1, c2_s1;
	logic signed [63:0] j_s1;

	always_ff @(posedge clk) begin
		if (adv[ST_S1]) begin
			ctx_s[ST_S1].x     <= stretch_1;
			ctx_s[ST_S1].y     <= stretch_2;
			ctx_s[ST_S1].scale <= stress_scale;
			ctx_s[ST_S1].rgn   <= rgn_c;
			ctx_s[ST_S1].st    <= st_c;
			ctx_s[ST_S1].pen1  <= '0;
			ctx_s[ST_S1].pen2  <= '0;
			ctx_s[ST_S1].ms1   <= '0;
			ctx_s[ST_S1].ms2   <= '0;
			d1_s1 <= d1_c;
			d2_s1 <= d2_c;
			c1_s1 <= c1_c;
			c2_s1 <= c2_c;
			j_s1  <= j_c;
		end
	end

	// ---------------- stage 2: penalties, sign check, leading one ----------------
	logic signed [67:0] pp1_c, pp2_c;
	logic [5:0]         p_c;
	enh_pkg::status_t   st2_c;

	assign pp1_c = d1_s1 * $signed({1'b0, c1_s1});
	assign pp2_c = d2_s1 * $signed({1'b0, c2_s1});

	always_comb begin
		p_c = '0;
		for (int i = 0; i < 64; i++) begin
			if (j_s1[i]) begin
				p_c = 6'(i);
			end
		end
	end

	always_comb begin
		st2_c = ctx_s[ST_S1].st;
		if (ctx_s[ST_S1].st == enh_pkg::ST_OK && j_s1 <= 64'sd0) begin
			st2_c = enh_pkg::ST_NONPOS;
		end
	end

	logic [63:0] j_s2;
	logic [5:0]  p_s2;

	always_ff @(posedge clk) begin
		if (adv[ST_S2]) begin
			ctx_s[ST_S2]      <= ctx_s[ST_S1];
			ctx_s[ST_S2].st   <= st2_c;
			ctx_s[ST_S2].pen1 <= pp1_c[67:16];
			ctx_s[ST_S2].pen2 <= pp2_c[67:16];
			j_s2 <= j_s1;
			p_s2 <= p_c;
		end
	end

	// ---------------- stage 3: normalize J to Q1.30, mu*s ----------------
	logic [63:0]        norm_c;
	logic signed [63:0] mx_c, my_c;

	assign norm_c = j_s2 << (~p_s2);
	assign mx_c   = $signed({1'b0, mu_q}) * ctx_s[ST_S2].x;
	assign my_c   = $signed({1'b0, mu_q}) * ctx_s[ST_S2].y;

	logic [30:0]     sq_m_s    [0:SQW];
	logic [SQW-1:0]  sq_frac_s [0:SQW];
	logic [5:0]      sq_p_s    [0:SQW];

	always_ff @(posedge clk) begin
		if (adv[ST_S3]) begin
			ctx_s[ST_S3]     <= ctx_s[ST_S2];
			ctx_s[ST_S3].ms1 <= mx_c[63:16];
			ctx_s[ST_S3].ms2 <= my_c[63:16];
			sq_m_s[0]        <= norm_c[63:33];
			sq_frac_s[0]     <= '0;
			sq_p_s[0]        <= p_s2;
		end
	end

	// ---------------- squaring stages: one log2 fraction bit each ----------------
	for (genvar g = 0; g < SQW; g++) begin : g_sq
		logic [61:0] sqp;
		logic [31:0] t;

		assign sqp = sq_m_s[g] * sq_m_s[g];
		assign t   = sqp[61:30];

		always_ff @(posedge clk) begin
			if (adv[ST_SQ0+g]) begin
				ctx_s[ST_SQ0+g] <= ctx_s[ST_SQ0+g-1];
				sq_m_s[g+1]     <= t[31] ? t[31:1] : t[30:0];
				sq_frac_s[g+1]  <= {sq_frac_s[g][SQW-2:0], t[31]};
				sq_p_s[g+1]     <= sq_p_s[g];
			end
		end
	end

	// ---------------- stage 20: ln J = log2 J * ln 2 ----------------
	logic signed [6:0]  pe_c;
	logic signed [22:0] l2_c;
	logic signed [55:0] lp_c;
	logic signed [23:0] lnj_s20;

	assign pe_c = $signed({1'b0, sq_p_s[SQW]}) - 7'sd32;
	assign l2_c = {pe_c, sq_frac_s[SQW]};
	assign lp_c = l2_c * $signed({1'b0, enh_pkg::LN2_Q32});

	always_ff @(posedge clk) begin
		if (adv[ST_LN]) begin
			ctx_s[ST_LN] <= ctx_s[ST_LN-1];
			lnj_s20      <= lp_c[55:32];
		end
	end

	// ---------------- stage 21: n = lambda*lnJ - mu*2^16 ----------------
	logic signed [55:0] nl_c;
	logic signed [55:0] n_s21;

	assign nl_c = $signed({1'b0, lambda_q}) * lnj_s20;

	always_ff @(posedge clk) begin
		if (adv[ST_N]) begin
			ctx_s[ST_N] <= ctx_s[ST_LN];
			n_s21       <= nl_c - $signed({9'b0, mu_q, 16'b0});
		end
	end

	// ---------------- stage 22: magnitudes and quotient signs ----------------
	logic [55:0] nmag_c;
	logic [31:0] xmag_c, ymag_c;

	assign nmag_c = n_s21[55] ? 56'(-n_s21) : 56'(n_s21);
	assign xmag_c = ctx_s[ST_N].x[31] ? 32'(-ctx_s[ST_N].x) : 32'(ctx_s[ST_N].x);
	assign ymag_c = ctx_s[ST_N].y[31] ? 32'(-ctx_s[ST_N].y) : 32'(ctx_s[ST_N].y);

	logic [31:0]   dv1_s  [0:DW];
	logic [31:0]   dv2_s  [0:DW];
	logic [31:0]   rem1_s [0:DW];
	logic [31:0]   rem2_s [0:DW];
	logic [DW-1:0] dq1_s  [0:DW];
	logic [DW-1:0] dq2_s  [0:DW];
	logic          sg1_s  [0:DW];
	logic          sg2_s  [0:DW];

	always_ff @(posedge clk) begin
		if (adv[ST_ABS]) begin
			ctx_s[ST_ABS] <= ctx_s[ST_N];
			dv1_s[0]      <= xmag_c;
			dv2_s[0]      <= ymag_c;
			rem1_s[0]     <= '0;
			rem2_s[0]     <= '0;
			dq1_s[0]      <= nmag_c[DW-1:0];
			dq2_s[0]      <= nmag_c[DW-1:0];
			sg1_s[0]      <= n_s21[55] ^ ctx_s[ST_N].x[31];
			sg2_s[0]      <= n_s21[55] ^ ctx_s[ST_N].y[31];
		end
	end

	// ---------------- restoring dividers: one quotient bit per stage ----------------
	for (genvar g = 0; g < DW; g++) begin : g_div
		logic [32:0] sh1, sh2, df1, df2;
		logic        q1, q2;

		assign sh1 = {rem1_s[g], dq1_s[g][DW-1]};
		assign sh2 = {rem2_s[g], dq2_s[g][DW-1]};
		assign df1 = sh1 - {1'b0, dv1_s[g]};
		assign df2 = sh2 - {1'b0, dv2_s[g]};
		assign q1  = !df1[32];
		assign q2  = !df2[32];

		always_ff @(posedge clk) begin
			if (adv[ST_DIV0+g]) begin
				ctx_s[ST_DIV0+g] <= ctx_s[ST_DIV0+g-1];
				dv1_s[g+1]       <= dv1_s[g];
				dv2_s[g+1]       <= dv2_s[g];
				rem1_s[g+1]      <= q1 ? df1[31:0] : sh1[31:0];
				rem2_s[g+1]      <= q2 ? df2[31:0] : sh2[31:0];
				dq1_s[g+1]       <= {dq1_s[g][DW-2:0], q1};
				dq2_s[g+1]       <= {dq2_s[g][DW-2:0], q2};
				sg1_s[g+1]       <= sg1_s[g];
				sg2_s[g+1]       <= sg2_s[g];
			end
		end
	end

	// ---------------- stage 77: sum of terms, clamp ----------------
	logic signed [DW:0]   q1p_c, q2p_c, q1_c, q2_c;
	logic signed [56:0]   sum1_c, sum2_c;
	logic signed [56:0]   cl1_c, cl2_c;
	logic signed [enh_pkg::SUM_W-1:0] sum1_s77, sum2_s77;

	assign q1p_c  = $signed({1'b0, dq1_s[DW]});
	assign q2p_c  = $signed({1'b0, dq2_s[DW]});
	assign q1_c   = sg1_s[DW] ? -q1p_c : q1p_c;
	assign q2_c   = sg2_s[DW] ? -q2p_c : q2p_c;
	assign sum1_c = 57'(ctx_s[ST_SUM-1].ms1) + 57'(q1_c) + 57'(ctx_s[ST_SUM-1].pen1);
	assign sum2_c = 57'(ctx_s[ST_SUM-1].ms2) + 57'(q2_c) + 57'(ctx_s[ST_SUM-1].pen2);

	always_comb begin
		cl1_c = sum1_c;
		if (sum1_c > enh_pkg::SUM_MAX) cl1_c = enh_pkg::SUM_MAX;
		if (sum1_c < enh_pkg::SUM_MIN) cl1_c = enh_pkg::SUM_MIN;
		cl2_c = sum2_c;
		if (sum2_c > enh_pkg::SUM_MAX) cl2_c = enh_pkg::SUM_MAX;
		if (sum2_c < enh_pkg::SUM_MIN) cl2_c = enh_pkg::SUM_MIN;
	end

	always_ff @(posedge clk) begin
		if (adv[ST_SUM]) begin
			ctx_s[ST_SUM] <= ctx_s[ST_SUM-1];
			sum1_s77      <= cl1_c[enh_pkg::SUM_W-1:0];
			sum2_s77      <= cl2_c[enh_pkg::SUM_W-1:0];
		end
	end

	// ---------------- stage 78: sum * scale as high and low partial products ----------------
	logic signed [64:0] ph1_c, ph2_c;
	logic signed [48:0] pl1_c, pl2_c;
	logic signed [64:0] ph1_s78, ph2_s78;
	logic signed [32:0] pl1_s78, pl2_s78;

	// high part is the floored sum / 2^16, kept signed
	assign ph1_c = $signed(sum1_s77[48:16]) * ctx_s[ST_SUM].scale;
	assign ph2_c = $signed(sum2_s77[48:16]) * ctx_s[ST_SUM].scale;
	assign pl1_c = $signed({1'b0, sum1_s77[15:0]}) * ctx_s[ST_SUM].scale;
	assign pl2_c = $signed({1'b0, sum2_s77[15:0]}) * ctx_s[ST_SUM].scale;

	always_ff @(posedge clk) begin
		if (adv[ST_MUL]) begin
			ctx_s[ST_MUL] <= ctx_s[ST_SUM];
			ph1_s78       <= ph1_c;
			ph2_s78       <= ph2_c;
			pl1_s78       <= pl1_c[48:16];
			pl2_s78       <= pl2_c[48:16];
		end
	end

	// ---------------- stage 79: combine, saturate, zero on error ----------------
	logic signed [65:0] tot1_c, tot2_c;
	logic signed [31:0] sat1_c, sat2_c;
	logic               ok_c;

	assign tot1_c = 66'(ph1_s78) + 66'(pl1_s78);
	assign tot2_c = 66'(ph2_s78) + 66'(pl2_s78);
	assign ok_c   = (ctx_s[ST_MUL].st == enh_pkg::ST_OK);

	always_comb begin
		sat1_c = tot1_c[31:0];
		if (tot1_c > 66'sd2147483647)  sat1_c = 32'sh7fffffff;
		if (tot1_c < -66'sd2147483648) sat1_c = 32'sh80000000;
		sat2_c = tot2_c[31:0];
		if (tot2_c > 66'sd2147483647)  sat2_c = 32'sh7fffffff;
		if (tot2_c < -66'sd2147483648) sat2_c = 32'sh80000000;
	end

	always_ff @(posedge clk) begin
		if (adv[ST_OUT]) begin
			stress_1 <= ok_c ? sat1_c : 32'sd0;
			stress_2 <= ok_c ? sat2_c : 32'sd0;
			region   <= ctx_s[ST_MUL].rgn;
			status   <= ctx_s[ST_MUL].st;
		end
	end

	// ---------------- assertions ----------------
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != enh_pkg::ST_OK |-> stress_1 == 32'sd0 && stress_2 == 32'sd0)
		else $error("error status with nonzero stress");

	a_noregion_main: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == enh_pkg::ST_NO_REGION |-> region == enh_pkg::RGN_MAIN)
		else $error("unmatched point reports a region");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output is free");

endmodule
